// File: hw/rtl/column_predicate_filter_assert.svh
// Assertion macros used by the batch accumulator of the column predicate filter RTL.
`ifndef COLUMN_PREDICATE_FILTER_ASSERT_SVH
`define COLUMN_PREDICATE_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cpf_pkg.sv
// Types and constants of the column predicate filter.
`default_nettype none

package cpf_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;

    // Compare modes; codes 6 and 7 never pass the compare
    localparam logic [MODE_W-1:0] MODE_LT       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LE       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_EQ       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GE       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GT       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ISNULL   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ARGUMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HAS_NULL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALL_NULL = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  compare_mode;
        logic [VALUE_W-1:0] compare_argument;
        logic               column_holds_null;
        logic               column_all_null;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] row_value;
        logic               row_is_null;
        logic               prior_match;
        logic               last_row;
    } t_row;

    typedef struct packed {
        logic row_match;
        logic set_match;
        logic set_mismatch;
    } t_eval;

endpackage

`default_nettype wire

// File: hw/rtl/cpf_cfg_regs.sv
// Configuration register file of the column predicate filter.
`default_nettype none

module cpf_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cpf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [cpf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output cpf_pkg::t_cfg                          o_cfg
);

    cpf_pkg::t_cfg r_cfg;
    cpf_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                cpf_pkg::CFG_IDX_MODE: begin
                    n_cfg.compare_mode = i_cfg_data[cpf_pkg::MODE_W-1:0];
                end
                cpf_pkg::CFG_IDX_ARGUMENT: begin
                    n_cfg.compare_argument = i_cfg_data[cpf_pkg::VALUE_W-1:0];
                end
                cpf_pkg::CFG_IDX_HAS_NULL: begin
                    n_cfg.column_holds_null = i_cfg_data[0];
                end
                cpf_pkg::CFG_IDX_ALL_NULL: begin
                    n_cfg.column_all_null = i_cfg_data[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.compare_mode      <= cpf_pkg::MODE_EQ;
            r_cfg.compare_argument  <= '0;
            r_cfg.column_holds_null <= 1'b0;
            r_cfg.column_all_null   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/cpf_row_eval.sv
// Per-row predicate evaluation: compare, null test and statistics fast paths.
`default_nettype none

module cpf_row_eval (
    input  wire cpf_pkg::t_cfg i_cfg,
    input  wire cpf_pkg::t_row i_row,
    output cpf_pkg::t_eval     o_eval
);

    logic is_lt;
    logic is_eq;
    logic cmp_pass;
    logic ord_match;

    assign is_lt = $signed(i_row.row_value) < $signed(i_cfg.compare_argument);
    assign is_eq = i_row.row_value == i_cfg.compare_argument;

    always_comb begin
        case (i_cfg.compare_mode)
            cpf_pkg::MODE_LT: cmp_pass = is_lt;
            cpf_pkg::MODE_LE: cmp_pass = is_lt | is_eq;
            cpf_pkg::MODE_EQ: cmp_pass = is_eq;
            cpf_pkg::MODE_GE: cmp_pass = ~is_lt;
            cpf_pkg::MODE_GT: cmp_pass = ~is_lt & ~is_eq;
            default:          cmp_pass = 1'b0;
        endcase
    end

    always_comb begin
        ord_match = 1'b0;
        o_eval    = '0;
        if (i_cfg.compare_mode == cpf_pkg::MODE_ISNULL) begin
            if (!i_cfg.column_holds_null) begin
                // no nulls in the column: prior match passes through, batch sees a mismatch
                o_eval.row_match    = i_row.prior_match;
                o_eval.set_mismatch = 1'b1;
            end else if (i_cfg.column_all_null) begin
                o_eval.row_match = i_row.prior_match;
                o_eval.set_match = 1'b1;
            end else begin
                ord_match           = i_row.prior_match & i_row.row_is_null;
                o_eval.row_match    = ord_match;
                o_eval.set_match    = ord_match;
                o_eval.set_mismatch = ~ord_match;
            end
        end else begin
            if (i_cfg.column_all_null) begin
                o_eval.row_match    = i_row.prior_match;
                o_eval.set_mismatch = 1'b1;
            end else begin
                ord_match           = i_row.prior_match & ~i_row.row_is_null & cmp_pass;
                o_eval.row_match    = ord_match;
                o_eval.set_match    = ord_match;
                o_eval.set_mismatch = ~ord_match;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cpf_batch_acc.sv
// Batch match/mismatch accumulators and the result register.
`default_nettype none

`include "column_predicate_filter_assert.svh"

module cpf_batch_acc (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire logic     i_last_row,
    input  wire cpf_pkg::t_eval i_eval,
    input  wire logic     i_out_stall,
    output logic          o_out_valid,
    output logic          o_row_match,
    output logic          o_batch_any_match,
    output logic          o_batch_any_mismatch,
    output logic          o_batch_done
);

    logic r_match_seen;
    logic r_mismatch_seen;
    logic n_match_seen;
    logic n_mismatch_seen;
    logic r_out_valid;
    logic n_out_valid;
    logic r_row_match;
    logic r_any_match;
    logic r_any_mismatch;
    logic r_done;
    logic seen_match;
    logic seen_mismatch;

    assign seen_match    = r_match_seen | i_eval.set_match;
    assign seen_mismatch = r_mismatch_seen | i_eval.set_mismatch;

    always_comb begin
        n_match_seen    = r_match_seen;
        n_mismatch_seen = r_mismatch_seen;
        if (i_load) begin
            // last row reports and clears
            n_match_seen    = seen_match & ~i_last_row;
            n_mismatch_seen = seen_mismatch & ~i_last_row;
        end
        if (i_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_seen    <= 1'b0;
            r_mismatch_seen <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_match_seen    <= n_match_seen;
            r_mismatch_seen <= n_mismatch_seen;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row_match    <= i_eval.row_match;
            r_any_match    <= seen_match & i_last_row;
            r_any_mismatch <= seen_mismatch & i_last_row;
            r_done         <= i_last_row;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_row_match          = r_row_match;
    assign o_batch_any_match    = r_any_match;
    assign o_batch_any_mismatch = r_any_mismatch;
    assign o_batch_done         = r_done;

    `CPF_ASSERT_NOW(a_batch_flags_only_on_done, i_clk, i_rst_n,
        r_out_valid && !r_done, !r_any_match && !r_any_mismatch,
        "batch flags set on a result that does not close the batch")

    `CPF_ASSERT_NOW(a_done_reports_something, i_clk, i_rst_n,
        r_out_valid && r_done, r_any_match || r_any_mismatch,
        "closing result reports neither match nor mismatch")

    `CPF_ASSERT_NEXT(a_acc_clears_on_last, i_clk, i_rst_n,
        i_load && i_last_row, !r_match_seen && !r_mismatch_seen,
        "accumulators not cleared after the last row")

    `CPF_ASSERT_NEXT(a_load_gives_valid, i_clk, i_rst_n,
        i_load, r_out_valid,
        "loaded result not presented")

endmodule

`default_nettype wire

// File: hw/rtl/column_predicate_filter.sv
// Column predicate filter: streaming per-row match update over a column batch.
//
// Input channel: i_in_valid / o_in_stall with row_value, row_is_null,
// prior_match and last_row; a transaction completes on a clock edge with
// valid high and stall low. Output channel: o_out_valid / i_out_stall with
// one result per row (row_match, and on the last row the batch flags with
// batch_done set). Configuration: i_cfg_we, i_cfg_index, i_cfg_data, taken
// at any edge with i_cfg_we high; write only while no rows are in flight.
// The input transaction fills the input register; the compare and fast-path
// logic then feed the result register, which raises result valid. Throughput
// is one row per cycle while i_out_stall stays low, with the 64-bit compare
// between the two registers. The input register can take one row while a
// result waits; when i_out_stall holds, the result register and the input
// register fill and o_in_stall rises. Reset (synchronous, active low) empties
// the pipeline, clears the batch accumulators and returns the configuration to
// equal-compare against zero with both statistics flags clear.
`default_nettype none

module column_predicate_filter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cpf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cpf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [cpf_pkg::VALUE_W-1:0] i_row_value,
    input  wire logic                           i_row_is_null,
    input  wire logic                           i_prior_match,
    input  wire logic                           i_last_row,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_row_match,
    output logic                                o_batch_any_match,
    output logic                                o_batch_any_mismatch,
    output logic                                o_batch_done
);

    cpf_pkg::t_cfg  cfg;
    cpf_pkg::t_row  r_row;
    cpf_pkg::t_eval row_eval;
    logic           r_row_valid;
    logic           n_row_valid;
    logic           res_ready;
    logic           in_take;
    logic           res_load;

    cpf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // result register frees up when empty or being drained this cycle
    assign res_ready  = ~o_out_valid | ~i_out_stall;
    assign res_load   = r_row_valid & res_ready;
    assign o_in_stall = r_row_valid & ~res_ready;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_comb begin
        if (in_take) begin
            n_row_valid = 1'b1;
        end else if (res_ready) begin
            n_row_valid = 1'b0;
        end else begin
            n_row_valid = r_row_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= 1'b0;
        end else begin
            r_row_valid <= n_row_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_row.row_value   <= i_row_value;
            r_row.row_is_null <= i_row_is_null;
            r_row.prior_match <= i_prior_match;
            r_row.last_row    <= i_last_row;
        end
    end

    cpf_row_eval u_eval (
        .i_cfg  (cfg),
        .i_row  (r_row),
        .o_eval (row_eval)
    );

    cpf_batch_acc u_acc (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_load               (res_load),
        .i_last_row           (r_row.last_row),
        .i_eval               (row_eval),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_row_match          (o_row_match),
        .o_batch_any_match    (o_batch_any_match),
        .o_batch_any_mismatch (o_batch_any_mismatch),
        .o_batch_done         (o_batch_done)
    );

endmodule

`default_nettype wire
